// File: rtl/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked at every clock edge outside reset.
`define ASSERT_CLK(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Implication checked at every clock edge outside reset.
`define ASSERT_IMPL(label, pre, post, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (pre) |-> (post)) else $error(msg);

`endif

// File: rtl/jrcd_pkg.sv
package jrcd_pkg;

	localparam int BUFFER_BYTES = 262143;
	localparam logic [17:0] COUNT_CAP =
		18'((BUFFER_BYTES < 262143) ? BUFFER_BYTES : 262143);

	localparam int FIFO_DEPTH = 4;
	localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);

	localparam logic signed [17:0] DEPTH_MAX = 18'sh1ffff;
	localparam logic signed [17:0] DEPTH_MIN = 18'sh20000;

	localparam logic [17:0] MSGPACK_BYTES_RST = 18'd1024;
	localparam logic [17:0] EARLY_POS_RST     = 18'd1000;
	localparam logic [7:0]  WS_WINDOW_RST     = 8'd100;

	localparam logic [7:0] CH_LBRACE = 8'h7b;
	localparam logic [7:0] CH_RBRACE = 8'h7d;
	localparam logic [7:0] CH_QUOTE  = 8'h22;
	localparam logic [7:0] CH_BSLASH = 8'h5c;
	localparam logic [7:0] CH_SPACE  = 8'h20;

	typedef enum logic [1:0] {
		REG_MSGPACK_BYTES = 2'd0,
		REG_EARLY_POS     = 2'd1,
		REG_WS_WINDOW     = 2'd2,
		REG_UNUSED        = 2'd3
	} reg_idx_t;

	typedef enum logic [2:0] {
		FMT_SHORT    = 3'd0,
		FMT_JSON     = 3'd1,
		FMT_PREFIXED = 3'd2,
		FMT_MSGPACK  = 3'd3,
		FMT_UNKNOWN  = 3'd4
	} fmt_t;

	// classified input byte
	typedef struct packed {
		logic [7:0] data_byte;
		logic       starts_buffer;
		logic       is_space;
		logic       is_lbrace;
		logic       is_rbrace;
		logic       is_quote;
		logic       is_bslash;
		logic       is_mp_lead;
	} item_t;

	typedef struct packed {
		logic full;
		logic empty;
	} fifo_stat_t;

	typedef struct packed {
		logic                complete;
		fmt_t                format_code;
		logic signed [17:0]  nest_depth;
		logic [17:0]         bytes_seen;
	} result_t;

	function automatic logic is_space_f(input logic [7:0] c);
		return (c == CH_SPACE) || (c >= 8'h09 && c <= 8'h0d);
	endfunction

	function automatic logic is_mp_lead_f(input logic [7:0] c);
		return (c >= 8'h80 && c <= 8'h8f) || (c >= 8'ha0 && c <= 8'hbf) ||
			(c == 8'hde) || (c == 8'hdf);
	endfunction

endpackage

// File: rtl/jrcd_front.sv
module jrcd_front
	import jrcd_pkg::*;
(
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [7:0] in_byte,
	input  logic       in_start,
	input  fifo_stat_t stat,
	output logic       push,
	output item_t      item
);

	assign in_ready = !stat.full;
	assign push     = in_valid && !stat.full;

	always_comb begin
		item.data_byte     = in_byte;
		item.starts_buffer = in_start;
		item.is_space      = is_space_f(in_byte);
		item.is_lbrace     = (in_byte == CH_LBRACE);
		item.is_rbrace     = (in_byte == CH_RBRACE);
		item.is_quote      = (in_byte == CH_QUOTE);
		item.is_bslash     = (in_byte == CH_BSLASH);
		item.is_mp_lead    = is_mp_lead_f(in_byte);
	end

endmodule

// File: rtl/jrcd_fifo.sv
`include "assert_macros.svh"

module jrcd_fifo
	import jrcd_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push,
	input  item_t      wr_item,
	input  logic       pop,
	output item_t      rd_item,
	output fifo_stat_t stat
);

	localparam logic [FIFO_PTR_W:0] DEPTH_CNT = (FIFO_PTR_W + 1)'(FIFO_DEPTH);

	item_t                 mem_q [FIFO_DEPTH];
	logic [FIFO_PTR_W-1:0] wr_ptr_q;
	logic [FIFO_PTR_W-1:0] rd_ptr_q;
	logic [FIFO_PTR_W:0]   count_q;

	assign stat.full  = (count_q == DEPTH_CNT);
	assign stat.empty = (count_q == '0);
	assign rd_item    = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push)
				wr_ptr_q <= wr_ptr_q + 1'b1;
			if (pop)
				rd_ptr_q <= rd_ptr_q + 1'b1;
			if (push && !pop)
				count_q <= count_q + 1'b1;
			else if (pop && !push)
				count_q <= count_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_ptr_q] <= wr_item;
	end

	`ASSERT_CLK(a_count_bound, count_q <= DEPTH_CNT, "fifo count beyond depth")
	`ASSERT_IMPL(a_no_pop_empty, pop, !stat.empty, "pop from empty fifo")
	`ASSERT_IMPL(a_no_push_full, push, !stat.full, "push into full fifo")

endmodule

// File: rtl/jrcd_back.sv
`include "assert_macros.svh"

module jrcd_back
	import jrcd_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_valid,
	input  logic [1:0] cfg_index,
	input  logic [17:0] cfg_data,
	input  item_t      item,
	input  fifo_stat_t stat,
	output logic       pop,
	output logic       res_valid,
	input  logic       res_ready,
	output result_t    res
);

	// configuration
	logic [17:0] msgpack_bytes_q;
	logic [17:0] early_pos_q;
	logic [7:0]  ws_window_q;

	// per-buffer state
	logic [17:0]        cnt_q;
	logic               lead_brace_q;
	logic [31:0]        prefix_q;
	fmt_t               mode_q;
	logic signed [17:0] depth_q;
	logic               instr_q;
	logic               esc_q;
	logic               cand_q;
	logic [7:0]         cand_run_q;
	logic               done_q;
	logic               last_brace_q;
	logic               saw_mark_q;
	logic [7:0]         trail_run_q;

	logic               out_valid_q;
	result_t            out_q;

	logic [17:0]        n_cnt;
	logic               n_lead_brace;
	logic [31:0]        n_prefix;
	fmt_t               n_mode;
	logic signed [17:0] n_depth;
	logic               n_instr;
	logic               n_esc;
	logic               n_cand;
	logic [7:0]         n_cand_run;
	logic               n_done;
	logic               n_last_brace;
	logic               n_saw_mark;
	logic [7:0]         n_trail_run;
	result_t            n_res;

	assign pop       = !stat.empty && (!out_valid_q || res_ready);
	assign res_valid = out_valid_q;
	assign res       = out_q;

	always_comb begin
		logic [17:0] idx;
		logic        json_on;
		logic        json_done;
		fmt_t        fmt;

		if (item.starts_buffer) begin
			n_cnt        = '0;
			n_lead_brace = 1'b0;
			n_prefix     = '0;
			n_mode       = FMT_SHORT;
			n_depth      = '0;
			n_instr      = 1'b0;
			n_esc        = 1'b0;
			n_cand       = 1'b0;
			n_cand_run   = '0;
			n_done       = 1'b0;
			n_last_brace = 1'b0;
			n_saw_mark   = 1'b0;
			n_trail_run  = '0;
		end else begin
			n_cnt        = cnt_q;
			n_lead_brace = lead_brace_q;
			n_prefix     = prefix_q;
			n_mode       = mode_q;
			n_depth      = depth_q;
			n_instr      = instr_q;
			n_esc        = esc_q;
			n_cand       = cand_q;
			n_cand_run   = cand_run_q;
			n_done       = done_q;
			n_last_brace = last_brace_q;
			n_saw_mark   = saw_mark_q;
			n_trail_run  = trail_run_q;
		end

		idx     = n_cnt;
		json_on = 1'b0;

		// full buffer: the byte is dropped
		if (n_cnt < COUNT_CAP) begin
			n_cnt = idx + 18'd1;
			if (idx == '0) begin
				n_lead_brace = item.is_lbrace;
				if (item.is_lbrace)
					n_mode = FMT_JSON;
				else if (item.is_mp_lead)
					n_mode = FMT_MSGPACK;
				else
					n_mode = FMT_UNKNOWN;
			end
			if (idx < 18'd4)
				n_prefix[{idx[1:0], 3'b000} +: 8] = item.data_byte;
			if (idx == 18'd4 && !n_lead_brace && item.is_lbrace) begin
				n_mode  = FMT_PREFIXED;
				n_depth = '0;
				n_instr = 1'b0;
				n_esc   = 1'b0;
			end
			json_on = (n_mode == FMT_JSON) || (n_mode == FMT_PREFIXED);
		end

		if (json_on) begin
			// early-exit candidate watches raw bytes after its brace
			if (n_cand) begin
				if (item.is_space) begin
					n_cand_run = n_cand_run + 8'd1;
					if ({1'b0, n_cand_run} + 9'd1 >= {1'b0, ws_window_q}) begin
						n_done = 1'b1;
						n_cand = 1'b0;
					end
				end else begin
					n_cand = 1'b0;
				end
			end

			if (item.is_space) begin
				if (n_trail_run != 8'hff)
					n_trail_run = n_trail_run + 8'd1;
			end else begin
				n_saw_mark   = 1'b1;
				n_last_brace = item.is_rbrace;
				n_trail_run  = '0;
			end

			// a backslash escapes the next byte even outside strings
			priority if (n_esc) begin
				n_esc = 1'b0;
			end else if (item.is_bslash) begin
				n_esc = 1'b1;
			end else if (item.is_quote) begin
				n_instr = !n_instr;
			end else if (!n_instr) begin
				if (item.is_lbrace) begin
					if (n_depth != DEPTH_MAX)
						n_depth = n_depth + 18'sd1;
				end else if (item.is_rbrace) begin
					if (n_depth != DEPTH_MIN)
						n_depth = n_depth - 18'sd1;
					if (n_depth == '0 && idx > early_pos_q) begin
						if (ws_window_q <= 8'd1) begin
							n_done = 1'b1;
						end else begin
							n_cand     = 1'b1;
							n_cand_run = '0;
						end
					end
				end
			end
		end

		json_done = n_done || n_cand ||
			(n_depth == '0 && !n_instr && n_saw_mark && n_last_brace &&
			n_trail_run < ws_window_q);

		fmt = (n_cnt < 18'd2) ? FMT_SHORT : n_mode;

		n_res.format_code = fmt;
		n_res.nest_depth  = n_depth;
		n_res.bytes_seen  = n_cnt;
		unique case (fmt)
			FMT_JSON:     n_res.complete = json_done;
			FMT_PREFIXED: n_res.complete = json_done && (n_prefix[31:18] == '0) &&
				({1'b0, n_cnt} >= {1'b0, n_prefix[17:0]} + 19'd4);
			FMT_MSGPACK:  n_res.complete = (n_cnt >= msgpack_bytes_q);
			default:      n_res.complete = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			msgpack_bytes_q <= MSGPACK_BYTES_RST;
			early_pos_q     <= EARLY_POS_RST;
			ws_window_q     <= WS_WINDOW_RST;
		end else if (cfg_valid) begin
			unique case (reg_idx_t'(cfg_index))
				REG_MSGPACK_BYTES: msgpack_bytes_q <= cfg_data;
				REG_EARLY_POS:     early_pos_q     <= cfg_data;
				REG_WS_WINDOW:     ws_window_q     <= cfg_data[7:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q        <= '0;
			lead_brace_q <= 1'b0;
			prefix_q     <= '0;
			mode_q       <= FMT_SHORT;
			depth_q      <= '0;
			instr_q      <= 1'b0;
			esc_q        <= 1'b0;
			cand_q       <= 1'b0;
			cand_run_q   <= '0;
			done_q       <= 1'b0;
			last_brace_q <= 1'b0;
			saw_mark_q   <= 1'b0;
			trail_run_q  <= '0;
			out_valid_q  <= 1'b0;
		end else begin
			if (pop) begin
				cnt_q        <= n_cnt;
				lead_brace_q <= n_lead_brace;
				prefix_q     <= n_prefix;
				mode_q       <= n_mode;
				depth_q      <= n_depth;
				instr_q      <= n_instr;
				esc_q        <= n_esc;
				cand_q       <= n_cand;
				cand_run_q   <= n_cand_run;
				done_q       <= n_done;
				last_brace_q <= n_last_brace;
				saw_mark_q   <= n_saw_mark;
				trail_run_q  <= n_trail_run;
				out_valid_q  <= 1'b1;
			end else if (res_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop)
			out_q <= n_res;
	end

	`ASSERT_IMPL(a_cand_depth, cand_q, depth_q == '0, "early candidate at nonzero depth")
	`ASSERT_IMPL(a_cand_json, cand_q || done_q,
		mode_q == FMT_JSON || mode_q == FMT_PREFIXED, "early exit outside json")
	`ASSERT_CLK(a_cnt_cap, cnt_q <= COUNT_CAP, "byte count beyond capacity")

endmodule

// File: rtl/json_response_completeness_detector.sv
// JSON response completeness detector.
// Slave stream: one buffer byte per transaction in s_axis_tdata[7:0];
// s_axis_tuser set marks the first byte of a new buffer and clears all
// per-buffer state. Master stream: one result per input byte, carrying
// complete, brace depth and bytes seen in m_axis_tdata and the format
// code in m_axis_tuser.
// Config channel: cfg_index 0 MessagePack byte total, 1 early-exit
// position, 2 whitespace window; index 3 is ignored. cfg_ready is always
// high; write only while no bytes are in flight.
// Path: the classified byte lands in a 4-entry queue and is read from
// it through the state update into the output register when that
// register is free or is being taken by the receiver.
// Throughput: one byte per cycle while the receiver does not stall, set by the combinational state update.
// Reset: registers take their defaults, the buffer state is empty.
// When the receiver stalls the result holds, the queue fills and then
// s_axis_tready drops; after the stall it rises again once the held
// result is taken and a byte leaves the queue.
module json_response_completeness_detector
	import jrcd_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
	input  logic        s_axis_tuser,   // [0] starts_buffer
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [39:0] m_axis_tdata,   // [0] complete, [18:1] nest_depth,
	                                    // [36:19] bytes_seen, [39:37] zero
	output logic [2:0]  m_axis_tuser,   // [2:0] format_code
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [17:0] cfg_data
);

	item_t      fr_item;
	item_t      bk_item;
	fifo_stat_t stat;
	logic       push;
	logic       pop;
	result_t    res;

	assign cfg_ready = 1'b1;

	jrcd_front u_front (
		.in_valid (s_axis_tvalid),
		.in_ready (s_axis_tready),
		.in_byte  (s_axis_tdata),
		.in_start (s_axis_tuser),
		.stat     (stat),
		.push     (push),
		.item     (fr_item)
	);

	jrcd_fifo u_fifo (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.wr_item (fr_item),
		.pop     (pop),
		.rd_item (bk_item),
		.stat    (stat)
	);

	jrcd_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.item      (bk_item),
		.stat      (stat),
		.pop       (pop),
		.res_valid (m_axis_tvalid),
		.res_ready (m_axis_tready),
		.res       (res)
	);

	assign m_axis_tdata = {3'b000, res.bytes_seen, res.nest_depth, res.complete};
	assign m_axis_tuser = res.format_code;

endmodule

// File: tb/tb_json_response_completeness_detector.sv
`timescale 1ns / 1ps

module tb_json_response_completeness_detector
	import jrcd_pkg::*;
();

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [7:0]  s_axis_tdata = 8'h00;   // [7:0] data_byte
	logic        s_axis_tuser = 1'b0;    // [0] starts_buffer
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [39:0] m_axis_tdata;           // [0] complete, [18:1] nest_depth,
	                                     // [36:19] bytes_seen
	logic [2:0]  m_axis_tuser;           // [2:0] format_code
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [1:0]  cfg_index = 2'd0;
	logic [17:0] cfg_data = 18'd0;

	json_response_completeness_detector dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.s_axis_tuser(s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.m_axis_tuser(m_axis_tuser),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always #1 clk = ~clk;

	// register copies
	logic [17:0] msgpack_total = MSGPACK_BYTES_RST;
	logic [17:0] early_pos = EARLY_POS_RST;
	logic [7:0]  ws_window = WS_WINDOW_RST;

	// buffer scan state
	int unsigned scan_count;
	logic [7:0]  scan_lead;
	int unsigned scan_prefix;
	fmt_t        scan_mode = FMT_SHORT;
	int          scan_depth;
	bit          quote_open, escape_next, exit_armed, exit_latched;
	bit          last_is_close, any_mark;
	int unsigned exit_blank_run, tail_blank_run;

	result_t     expected_status_q[$];
	logic [7:0]  frame_bytes[$];

	int sender_idle_pct = 0;
	int recv_idle_pct = 0;
	int hold_request = 0;
	int hold_left = 0;

	int mismatches = 0;
	int bytes_sent = 0;
	int frames_sent = 0;
	int completes_seen = 0;
	int results_seen = 0;
	int fmt_hits[5];

	function automatic bit is_blank(input logic [7:0] c);
		return c == CH_SPACE || (c >= 8'h09 && c <= 8'h0d);
	endfunction

	function automatic bit is_packed_lead(input logic [7:0] c);
		return (c >= 8'h80 && c <= 8'h8f) || (c >= 8'ha0 && c <= 8'hbf) ||
			c == 8'hde || c == 8'hdf;
	endfunction

	function automatic void clear_scan();
		scan_count = 0;
		scan_lead = 8'h00;
		scan_prefix = 0;
		scan_mode = FMT_SHORT;
		scan_depth = 0;
		quote_open = 1'b0;
		escape_next = 1'b0;
		exit_armed = 1'b0;
		exit_blank_run = 0;
		exit_latched = 1'b0;
		last_is_close = 1'b0;
		any_mark = 1'b0;
		tail_blank_run = 0;
	endfunction

	function automatic void scan_json_byte(input logic [7:0] c, input int unsigned idx);
		// armed early exit looks at raw bytes, strings or not
		if (exit_armed) begin
			if (is_blank(c)) begin
				exit_blank_run++;
				if (exit_blank_run + 1 >= ws_window) begin
					exit_latched = 1'b1;
					exit_armed = 1'b0;
				end
			end else begin
				exit_armed = 1'b0;
			end
		end
		if (is_blank(c)) begin
			if (tail_blank_run < 255)
				tail_blank_run++;
		end else begin
			any_mark = 1'b1;
			last_is_close = (c == CH_RBRACE);
			tail_blank_run = 0;
		end
		if (escape_next) begin
			escape_next = 1'b0;
		end else if (c == CH_BSLASH) begin
			escape_next = 1'b1;
		end else if (c == CH_QUOTE) begin
			quote_open = !quote_open;
		end else if (!quote_open) begin
			if (c == CH_LBRACE) begin
				if (scan_depth < DEPTH_MAX)
					scan_depth++;
			end else if (c == CH_RBRACE) begin
				if (scan_depth > DEPTH_MIN)
					scan_depth--;
				if (scan_depth == 0 && idx > early_pos) begin
					if (ws_window <= 1) begin
						exit_latched = 1'b1;
					end else begin
						exit_armed = 1'b1;
						exit_blank_run = 0;
					end
				end
			end
		end
	endfunction

	function automatic bit json_done();
		if (exit_latched || exit_armed)
			return 1'b1;
		return scan_depth == 0 && !quote_open && any_mark && last_is_close &&
			tail_blank_run < ws_window;
	endfunction

	function automatic result_t next_status(input logic [7:0] c, input bit fresh);
		result_t          r;
		int unsigned      idx;
		fmt_t             f;
		bit               done;
		longint unsigned  need;
		if (fresh)
			clear_scan();
		if (scan_count < COUNT_CAP) begin
			idx = scan_count;
			scan_count++;
			if (idx == 0) begin
				scan_lead = c;
				if (c == CH_LBRACE)
					scan_mode = FMT_JSON;
				else if (is_packed_lead(c))
					scan_mode = FMT_MSGPACK;
				else
					scan_mode = FMT_UNKNOWN;
			end
			if (idx < 4)
				scan_prefix |= 32'(c) << (8 * idx);
			if (idx == 4 && scan_lead != CH_LBRACE && c == CH_LBRACE) begin
				scan_mode = FMT_PREFIXED;
				scan_depth = 0;
				quote_open = 1'b0;
				escape_next = 1'b0;
			end
			if (scan_mode == FMT_JSON || (scan_mode == FMT_PREFIXED && idx >= 4))
				scan_json_byte(c, idx);
		end
		f = (scan_count < 2) ? FMT_SHORT : scan_mode;
		done = 1'b0;
		case (f)
			FMT_JSON: done = json_done();
			FMT_PREFIXED: begin
				need = 64'(scan_prefix) + 64'd4;
				if (64'(scan_count) >= need)
					done = json_done();
			end
			FMT_MSGPACK: done = scan_count >= msgpack_total;
			default: done = 1'b0;
		endcase
		r.complete = done;
		r.format_code = f;
		r.nest_depth = scan_depth[17:0];
		r.bytes_seen = scan_count[17:0];
		return r;
	endfunction

	// register writes
	always @(posedge clk) begin
		if (arst_n && cfg_valid && cfg_ready) begin
			case (reg_idx_t'(cfg_index))
				REG_MSGPACK_BYTES: msgpack_total = cfg_data;
				REG_EARLY_POS:     early_pos = cfg_data;
				REG_WS_WINDOW:     ws_window = cfg_data[7:0];
				default: ;
			endcase
		end
	end

	// accepted input byte -> expected status
	always @(posedge clk) begin
		result_t st;
		if (arst_n && s_axis_tvalid && s_axis_tready) begin
			st = next_status(s_axis_tdata, s_axis_tuser);
			expected_status_q = {expected_status_q, st};
			if (st.complete)
				completes_seen++;
			fmt_hits[st.format_code]++;
		end
	end

	// result checker
	always @(posedge clk) begin
		result_t want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			results_seen++;
			if (expected_status_q.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result: complete %0d fmt %0d depth %0d bytes %0d",
						m_axis_tdata[0], m_axis_tuser, $signed(m_axis_tdata[18:1]),
						m_axis_tdata[36:19]);
			end else begin
				want = expected_status_q.pop_front();
				if (m_axis_tdata[0] !== want.complete ||
						m_axis_tuser !== want.format_code ||
						m_axis_tdata[18:1] !== want.nest_depth ||
						m_axis_tdata[36:19] !== want.bytes_seen) begin
					mismatches++;
					if (mismatches <= 10)
						$display({"mismatch at result %0d: expected complete %0d fmt %0d ",
							"depth %0d bytes %0d, got complete %0d fmt %0d depth %0d ",
							"bytes %0d"}, results_seen, want.complete,
							want.format_code, $signed(want.nest_depth), want.bytes_seen,
							m_axis_tdata[0], m_axis_tuser, $signed(m_axis_tdata[18:1]),
							m_axis_tdata[36:19]);
				end
			end
		end
	end

	// receiver: random stalls, plus long hold-offs on request
	always @(negedge clk) begin
		if (hold_request > 0) begin
			hold_left = hold_request;
			hold_request = 0;
		end
		if (hold_left > 0) begin
			hold_left--;
			m_axis_tready <= 1'b0;
		end else begin
			m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	task automatic send_byte(input logic [7:0] b, input bit fresh);
		@(negedge clk);
		while ($urandom_range(99) < sender_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= b;
		s_axis_tuser <= fresh;
		@(posedge clk);
		while (!s_axis_tready)
			@(posedge clk);
		bytes_sent++;
	endtask

	task automatic send_frame(input bit fresh);
		if (fresh)
			frames_sent++;
		foreach (frame_bytes[i])
			send_byte(frame_bytes[i], fresh && i == 0);
		frame_bytes.delete();
	endtask

	task automatic wait_idle();
		@(negedge clk);
		s_axis_tvalid <= 1'b0;
		while (expected_status_q.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(input reg_idx_t idx, input logic [17:0] val);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic set_regs(input logic [17:0] mp, input logic [17:0] ep,
			input logic [17:0] ws);
		wait_idle();
		write_reg(REG_MSGPACK_BYTES, mp);
		write_reg(REG_EARLY_POS, ep);
		write_reg(REG_WS_WINDOW, ws);
	endtask

	function automatic void add_byte(input logic [7:0] b);
		frame_bytes = {frame_bytes, b};
	endfunction

	function automatic logic [7:0] blank_byte();
		int r;
		r = $urandom_range(5);
		return (r == 5) ? CH_SPACE : 8'(8'h09 + r);
	endfunction

	function automatic logic [7:0] plain_char();
		return $urandom_range(1) ? 8'(8'h61 + $urandom_range(25)) : 8'h3a;
	endfunction

	function automatic void add_string();
		int n;
		add_byte(CH_QUOTE);
		n = $urandom_range(5);
		repeat (n) begin
			case ($urandom_range(5))
				0: begin
					add_byte(CH_BSLASH);
					case ($urandom_range(3))
						0: add_byte(CH_QUOTE);
						1: add_byte(CH_BSLASH);
						2: add_byte(CH_RBRACE);
						default: add_byte(plain_char());
					endcase
				end
				1: add_byte($urandom_range(1) ? CH_LBRACE : CH_RBRACE);
				default: add_byte(plain_char());
			endcase
		end
		if ($urandom_range(7) != 0)
			add_byte(CH_QUOTE);
	endfunction

	function automatic void add_json(input int budget);
		int open;
		add_byte(CH_LBRACE);
		open = 1;
		while (open > 0 && frame_bytes.size() < budget) begin
			case ($urandom_range(11))
				0, 1: begin
					add_byte(CH_LBRACE);
					open++;
				end
				2, 3: begin
					add_byte(CH_RBRACE);
					open--;
				end
				4: add_string();
				5: add_byte(blank_byte());
				6: if ($urandom_range(2) == 0) add_byte(CH_BSLASH);
				default: add_byte(plain_char());
			endcase
		end
		if ($urandom_range(7) != 0)
			repeat (open) add_byte(CH_RBRACE);
		// trailing blanks, sometimes right around the window size
		open = ($urandom_range(3) == 0) ? int'(ws_window) - 1 + $urandom_range(2)
			: $urandom_range(4);
		repeat (open) add_byte(blank_byte());
		if ($urandom_range(5) == 0)
			add_byte($urandom_range(1) ? CH_RBRACE : plain_char());
	endfunction

	function automatic void add_prefixed();
		logic [31:0] len;
		add_json($urandom_range(4, 30));
		case ($urandom_range(7))
			0: len = 32'hffff_ffff;
			1: len = 32'h0004_0000;
			2: len = 32'(frame_bytes.size() + $urandom_range(4));
			3: len = 32'(frame_bytes.size()) - 32'($urandom_range(3));
			default: len = 32'(frame_bytes.size());
		endcase
		if ($urandom_range(9) == 0)
			frame_bytes[0] = plain_char();
		for (int i = 3; i >= 0; i--)
			frame_bytes.push_front(len[8 * i +: 8]);
	endfunction

	function automatic void add_packed();
		int n;
		case ($urandom_range(7))
			0: add_byte(8'h80);
			1: add_byte(8'h8f);
			2: add_byte(8'ha0);
			3: add_byte(8'hbf);
			4: add_byte(8'hde);
			5: add_byte(8'hdf);
			6: add_byte(8'(8'h80 + $urandom_range(15)));
			default: add_byte(8'(8'ha0 + $urandom_range(31)));
		endcase
		n = int'(msgpack_total) + $urandom_range(3) - 2;
		if (n > 40)
			n = $urandom_range(10, 40);
		for (int i = 1; i < n; i++)
			add_byte(8'($urandom_range(255)));
	endfunction

	function automatic void add_noise(input int lo, input int hi);
		repeat ($urandom_range(lo, hi))
			add_byte(8'($urandom_range(255)));
	endfunction

	task automatic test_directed_formats();
		sender_idle_pct = 27;
		recv_idle_pct = 75;
		write_reg(REG_MSGPACK_BYTES, 18'd4);
		write_reg(REG_EARLY_POS, 18'd2);
		write_reg(REG_WS_WINDOW, 18'd3);
		write_reg(REG_UNUSED, 18'h3ffff);
		// early exit: depth back to zero past the position, then a blank
		frame_bytes = '{CH_LBRACE, CH_LBRACE, CH_RBRACE, CH_RBRACE, CH_SPACE};
		send_frame(1'b1);
		// length prefix fully present, end check
		frame_bytes = '{8'h02, 8'h00, 8'h00, 8'h00, CH_LBRACE, CH_RBRACE};
		send_frame(1'b1);
		frame_bytes = '{8'hdf, 8'h01, 8'h02, 8'h03};
		send_frame(1'b1);
		frame_bytes = '{8'h00, 8'hff};
		send_frame(1'b1);
		// backslash outside a string escapes the brace
		frame_bytes = '{CH_LBRACE, CH_BSLASH, CH_LBRACE, CH_RBRACE};
		send_frame(1'b1);
		// close brace and escaped quote inside a string
		frame_bytes = '{CH_LBRACE, CH_QUOTE, CH_RBRACE, CH_BSLASH, CH_QUOTE, CH_QUOTE,
			CH_RBRACE};
		send_frame(1'b1);
	endtask

	task automatic run_phase(input logic [17:0] mp, input logic [17:0] ep,
			input logic [17:0] ws, input int budget);
		int goal;
		int r;
		set_regs(mp, ep, ws);
		goal = bytes_sent + budget;
		while (bytes_sent < goal) begin
			r = $urandom_range(99);
			if (r < 50)
				add_json($urandom_range(2, 30));
			else if (r < 65)
				add_prefixed();
			else if (r < 78)
				add_packed();
			else if (r < 88)
				add_noise(2, 8);
			else
				add_noise(1, 12);
			send_frame(r < 95);
		end
	endtask

	task automatic test_random_phases();
		sender_idle_pct = 27;
		recv_idle_pct = 75;
		run_phase(18'd0, 18'd0, 18'd0, 150);
		run_phase(18'd1, 18'd0, 18'd1, 150);
		sender_idle_pct = 75;
		recv_idle_pct = 27;
		run_phase(18'h3ffff, 18'h3ffff, 18'h3ffff, 150);
		run_phase(18'd12, 18'd3, 18'd2, 150);
		sender_idle_pct = 0;
		recv_idle_pct = 0;
		run_phase(18'd30, 18'd8, 18'd6, 150);
		// window register keeps the low byte only
		run_phase(18'($urandom_range(60)), 18'($urandom_range(20)),
			{10'($urandom_range(1023)), 8'($urandom_range(1, 12))}, 150);
		run_phase(18'd6, 18'd1, 18'h100, 100);
	endtask

	task automatic test_backpressure();
		sender_idle_pct = 0;
		recv_idle_pct = 0;
		set_regs(18'd20, 18'd5, 18'd4);
		hold_request = 60;
		add_json(40);
		send_frame(1'b1);
		// sender waits for every result, then the same buffer carries on
		wait_idle();
		repeat (3) add_byte(blank_byte());
		add_byte(CH_RBRACE);
		send_frame(1'b0);
	endtask

	initial begin
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		test_directed_formats();
		test_random_phases();
		test_backpressure();
		wait_idle();
		repeat (20) @(posedge clk);
		mismatches += expected_status_q.size();
		$display("%0d bytes in %0d buffers, %0d results checked, %0d complete",
			bytes_sent, frames_sent, results_seen, completes_seen);
		$display("formats short/json/prefixed/msgpack/unknown: %0d/%0d/%0d/%0d/%0d",
			fmt_hits[0], fmt_hits[1], fmt_hits[2], fmt_hits[3], fmt_hits[4]);
		if (mismatches == 0)
			$display("json_response_completeness_detector regression: pass");
		else
			$display("json_response_completeness_detector regression: fail");
		$finish;
	end

	initial begin
		#5000000;
		$display("json_response_completeness_detector regression: fail");
		$finish;
	end

endmodule
